/* hw/rtl/c2p_pkg.sv */
// Shared constants, types and the arctangent table of the cartesian to polar block.
// Used by c2p_sqrt, c2p_cordic and cartesian_to_polar_top. No dependencies.

package c2p_pkg;

  // Number format of the coordinates and results.
  localparam int FRAC_BITS  = 16;
  localparam int COORD_W    = 32;
  localparam int MAG_W      = 32;
  localparam int ANGLE_W    = 25;

  // Square root: one result bit per pipeline step over a 64-bit radicand.
  localparam int SQ_W       = 2 * COORD_W;
  localparam int SQ_STEPS   = SQ_W / 2;

  // CORDIC angle accumulator and datapath.
  localparam int ITERATIONS = 24;
  localparam int ANG_FRAC   = 30;
  localparam int PRESHIFT   = 29;
  localparam int CX_W       = 64;
  localparam int ZW         = 33;
  localparam int ZC_W       = 31;
  localparam int R2D_W      = 30;
  localparam int PROD_W     = ZC_W + R2D_W;
  localparam int DEG2_SHIFT = ANG_FRAC + 24 - FRAC_BITS;

  localparam logic [ZC_W-1:0]  HALF_PI_Q30 = ZC_W'(1686629713);
  // 180/pi with 24 fraction bits.
  localparam logic [R2D_W-1:0] RAD2DEG_Q24 = R2D_W'(961263669);

  // Angle landmarks in degrees with FRAC_BITS fraction bits.
  localparam logic [63:0] D90_L  = 64'd90  << FRAC_BITS;
  localparam logic [63:0] D180_L = 64'd180 << FRAC_BITS;
  localparam logic [63:0] D360_L = 64'd360 << FRAC_BITS;
  localparam int          DEG_W  = $clog2(D360_L + 64'd1);

  // Pipeline depths of the two datapaths and of the aligned result.
  localparam int SQRT_LAT = SQ_STEPS + 3;
  localparam int CORD_LAT = ITERATIONS + 4;
  localparam int PIPE_LAT = (SQRT_LAT > CORD_LAT) ? SQRT_LAT : CORD_LAT;

  // Quadrant information that travels beside the angle datapath.
  typedef struct packed {
    logic x_neg;
    logic y_neg;
    logic origin;
  } side_t;

  // atan(2^-i) in radians with 30 fraction bits, rounded.
  function automatic logic [ZC_W-1:0] atan_q30(input logic [4:0] idx);
    logic [ZC_W-1:0] val;
    unique case (idx)
      5'd0:  val = ZC_W'(843314857);
      5'd1:  val = ZC_W'(497837829);
      5'd2:  val = ZC_W'(263043837);
      5'd3:  val = ZC_W'(133525159);
      5'd4:  val = ZC_W'(67021687);
      5'd5:  val = ZC_W'(33543516);
      5'd6:  val = ZC_W'(16775851);
      5'd7:  val = ZC_W'(8388437);
      5'd8:  val = ZC_W'(4194283);
      5'd9:  val = ZC_W'(2097149);
      5'd10: val = ZC_W'(1048576);
      5'd11: val = ZC_W'(524288);
      5'd12: val = ZC_W'(262144);
      5'd13: val = ZC_W'(131072);
      5'd14: val = ZC_W'(65536);
      5'd15: val = ZC_W'(32768);
      5'd16: val = ZC_W'(16384);
      5'd17: val = ZC_W'(8192);
      5'd18: val = ZC_W'(4096);
      5'd19: val = ZC_W'(2048);
      5'd20: val = ZC_W'(1024);
      5'd21: val = ZC_W'(512);
      5'd22: val = ZC_W'(256);
      5'd23: val = ZC_W'(128);
      5'd24: val = ZC_W'(64);
      5'd25: val = ZC_W'(32);
      5'd26: val = ZC_W'(16);
      5'd27: val = ZC_W'(8);
      5'd28: val = ZC_W'(4);
      5'd29: val = ZC_W'(2);
      5'd30: val = ZC_W'(1);
      5'd31: val = ZC_W'(0);
    endcase
    return val;
  endfunction

endpackage

/* hw/rtl/c2p_sqrt.sv */
// Pipelined magnitude unit: squares, sum and a rounded digit-by-digit square root.
// Depends on c2p_pkg.

module c2p_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [c2p_pkg::COORD_W-1:0] ax_i,
  input  logic [c2p_pkg::COORD_W-1:0] ay_i,
  output logic                       valid_o,
  output logic [c2p_pkg::MAG_W-1:0]  mag_o
);
  import c2p_pkg::*;

  logic            sq_vld_q;
  logic [SQ_W-1:0] xsq_q, ysq_q;
  logic            sum_vld_q;
  logic [SQ_W-1:0] sum_q;

  logic            step_vld_q  [SQ_STEPS];
  logic [SQ_W-1:0] step_rem_q  [SQ_STEPS];
  logic [SQ_W-1:0] step_root_q [SQ_STEPS];

  logic             out_vld_q;
  logic [MAG_W-1:0] mag_q, mag_d;

  // The two squares, one multiplier each.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= 1'b0;
    end else begin
      sq_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      xsq_q <= SQ_W'(ax_i) * SQ_W'(ax_i);
      ysq_q <= SQ_W'(ay_i) * SQ_W'(ay_i);
    end
  end

  // Sum of squares; it never exceeds 2^63, so 64 bits hold it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_vld_q <= 1'b0;
    end else begin
      sum_vld_q <= sq_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_vld_q) begin
      sum_q <= xsq_q + ysq_q;
    end
  end

  // One root bit per stage: trial subtract of root plus the current bit weight.
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);

    logic            vld_in;
    logic [SQ_W-1:0] rem_in, root_in, cand, rem_d, root_d;

    if (k == 0) begin : g_first
      assign vld_in  = sum_vld_q;
      assign rem_in  = sum_q;
      assign root_in = '0;
    end else begin : g_next
      assign vld_in  = step_vld_q[k-1];
      assign rem_in  = step_rem_q[k-1];
      assign root_in = step_root_q[k-1];
    end

    assign cand = root_in + BIT;

    always_comb begin
      if (rem_in >= cand) begin
        rem_d  = rem_in - cand;
        root_d = (root_in >> 1) + BIT;
      end else begin
        rem_d  = rem_in;
        root_d = root_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        step_vld_q[k] <= 1'b0;
      end else begin
        step_vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (vld_in) begin
        step_rem_q[k]  <= rem_d;
        step_root_q[k] <= root_d;
      end
    end
  end

  // Round to nearest: bump the root when the remainder exceeds it.
  assign mag_d = MAG_W'(step_root_q[SQ_STEPS-1])
               + MAG_W'(step_rem_q[SQ_STEPS-1] > step_root_q[SQ_STEPS-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= step_vld_q[SQ_STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_vld_q[SQ_STEPS-1]) begin
      mag_q <= mag_d;
    end
  end

  assign valid_o = out_vld_q;
  assign mag_o   = mag_q;

endmodule

/* hw/rtl/c2p_cordic.sv */
// Pipelined vectoring CORDIC giving the full-turn angle in degrees.
// Depends on c2p_pkg.

module c2p_cordic (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [c2p_pkg::COORD_W-1:0] ax_i,
  input  logic [c2p_pkg::COORD_W-1:0] ay_i,
  input  c2p_pkg::side_t              side_i,
  output logic                        valid_o,
  output logic [c2p_pkg::ANGLE_W-1:0] angle_o,
  output logic                        origin_o
);
  import c2p_pkg::*;

  logic                   it_vld_q  [ITERATIONS];
  logic signed [CX_W-1:0] it_cx_q   [ITERATIONS];
  logic signed [CX_W-1:0] it_cy_q   [ITERATIONS];
  logic signed [ZW-1:0]   it_z_q    [ITERATIONS];
  side_t                  it_side_q [ITERATIONS];

  logic                   clp_vld_q;
  logic [ZC_W-1:0]        zc_q, zc_d;
  side_t                  clp_side_q;

  logic                   mul_vld_q;
  logic [PROD_W-1:0]      prod_q;
  side_t                  mul_side_q;

  logic                   rnd_vld_q;
  logic [DEG_W-1:0]       t_q, t_d;
  logic [PROD_W:0]        prod_rnd;
  logic [PROD_W-DEG2_SHIFT:0] deg_full;
  side_t                  rnd_side_q;

  logic                   out_vld_q;
  logic [DEG_W-1:0]       ang_q, ang_d, ang_raw;
  logic                   origin_q;

  // Rotation stages: drive y toward zero and accumulate the angle.
  for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
    localparam logic signed [ZW-1:0] ATAN = signed'(ZW'(atan_q30(5'(i))));

    logic                   vld_in;
    logic signed [CX_W-1:0] cx_in, cy_in, dx, dy, cx_d, cy_d;
    logic signed [ZW-1:0]   z_in, z_d;
    side_t                  side_in;

    if (i == 0) begin : g_first
      assign vld_in  = valid_i;
      assign cx_in   = signed'(CX_W'(ax_i) << PRESHIFT);
      assign cy_in   = signed'(CX_W'(ay_i) << PRESHIFT);
      assign z_in    = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = it_vld_q[i-1];
      assign cx_in   = it_cx_q[i-1];
      assign cy_in   = it_cy_q[i-1];
      assign z_in    = it_z_q[i-1];
      assign side_in = it_side_q[i-1];
    end

    assign dx = cy_in >>> i;
    assign dy = cx_in >>> i;

    always_comb begin
      if (cy_in > 0) begin
        cx_d = cx_in + dx;
        cy_d = cy_in - dy;
        z_d  = z_in + ATAN;
      end else begin
        cx_d = cx_in - dx;
        cy_d = cy_in + dy;
        z_d  = z_in - ATAN;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        it_vld_q[i] <= 1'b0;
      end else begin
        it_vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (vld_in) begin
        it_cx_q[i]   <= cx_d;
        it_cy_q[i]   <= cy_d;
        it_z_q[i]    <= z_d;
        it_side_q[i] <= side_in;
      end
    end
  end

  // Clamp the first-quadrant angle to [0, pi/2].
  always_comb begin
    if (it_z_q[ITERATIONS-1] < 0) begin
      zc_d = '0;
    end else if (it_z_q[ITERATIONS-1] > signed'(ZW'(HALF_PI_Q30))) begin
      zc_d = HALF_PI_Q30;
    end else begin
      zc_d = ZC_W'(it_z_q[ITERATIONS-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clp_vld_q <= 1'b0;
      mul_vld_q <= 1'b0;
      rnd_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      clp_vld_q <= it_vld_q[ITERATIONS-1];
      mul_vld_q <= clp_vld_q;
      rnd_vld_q <= mul_vld_q;
      out_vld_q <= rnd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (it_vld_q[ITERATIONS-1]) begin
      zc_q       <= zc_d;
      clp_side_q <= it_side_q[ITERATIONS-1];
    end
  end

  // Radians to degrees: one constant multiply.
  always_ff @(posedge clk_i) begin
    if (clp_vld_q) begin
      prod_q     <= PROD_W'(zc_q) * PROD_W'(RAD2DEG_Q24);
      mul_side_q <= clp_side_q;
    end
  end

  // Round to FRAC_BITS fraction bits and cap at 90 degrees.
  assign prod_rnd = {1'b0, prod_q} + ((PROD_W + 1)'(1) << (DEG2_SHIFT - 1));
  assign deg_full = prod_rnd[PROD_W:DEG2_SHIFT];

  always_comb begin
    if (64'(deg_full) > D90_L) begin
      t_d = DEG_W'(D90_L);
    end else begin
      t_d = DEG_W'(deg_full);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_vld_q) begin
      t_q        <= t_d;
      rnd_side_q <= mul_side_q;
    end
  end

  // Place the angle in its quadrant; a full turn wraps to zero.
  always_comb begin
    unique case ({rnd_side_q.y_neg, rnd_side_q.x_neg})
      2'b00: ang_raw = t_q;
      2'b01: ang_raw = DEG_W'(D180_L) - t_q;
      2'b10: ang_raw = DEG_W'(D360_L) - t_q;
      2'b11: ang_raw = DEG_W'(D180_L) + t_q;
    endcase
    if (rnd_side_q.origin) begin
      ang_d = '0;
    end else if (ang_raw >= DEG_W'(D360_L)) begin
      ang_d = ang_raw - DEG_W'(D360_L);
    end else begin
      ang_d = ang_raw;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rnd_vld_q) begin
      ang_q    <= ang_d;
      origin_q <= rnd_side_q.origin;
    end
  end

  assign valid_o  = out_vld_q;
  assign angle_o  = ANGLE_W'(ang_q);
  assign origin_o = origin_q;

endmodule

/* hw/rtl/cartesian_to_polar_top.sv */
// Top level of the cartesian to polar converter: input register, the magnitude and
// angle pipelines, and latency alignment. Depends on c2p_pkg, c2p_sqrt and c2p_cordic.

// A point (x, y) is taken on every clock edge where start is high; busy is always low,
// so one transaction can enter every cycle. Its result appears on the result ports,
// marked by done_o for exactly one cycle, once it has passed the input register and the
// longer pipeline. The square root pipeline is the longer one, resolving one of the 32
// magnitude bits per stage; the angle CORDIC (24 rotation stages) is padded to match.
// Results come out in the order the points went in, and the receiver cannot stall them.
// The origin gives magnitude 0, angle 0 and at_origin_o high.

module cartesian_to_polar_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [c2p_pkg::COORD_W-1:0] x_coord_i,
  input  logic signed [c2p_pkg::COORD_W-1:0] y_coord_i,
  output logic                               done_o,
  output logic [c2p_pkg::MAG_W-1:0]          magnitude_o,
  output logic [c2p_pkg::ANGLE_W-1:0]        angle_deg_o,
  output logic                               at_origin_o
);
  import c2p_pkg::*;

  localparam int MAG_PAD = PIPE_LAT - SQRT_LAT;
  localparam int ANG_PAD = PIPE_LAT - CORD_LAT;

  logic               accept;
  logic [COORD_W-1:0] x_raw, y_raw, ax_d, ay_d;
  logic               in_vld_q;
  logic [COORD_W-1:0] ax_q, ay_q;
  side_t              side_q, side_d;

  logic               sq_vld, cd_vld, cd_origin;
  logic [MAG_W-1:0]   sq_mag;
  logic [ANGLE_W-1:0] cd_angle;

  logic               mag_vld_pad, ang_vld_pad, origin_pad;
  logic [MAG_W-1:0]   mag_pad;
  logic [ANGLE_W-1:0] ang_pad;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Input register: absolute values, signs and the origin test.
  assign x_raw = x_coord_i;
  assign y_raw = y_coord_i;
  assign ax_d  = x_raw[COORD_W-1] ? (~x_raw + COORD_W'(1)) : x_raw;
  assign ay_d  = y_raw[COORD_W-1] ? (~y_raw + COORD_W'(1)) : y_raw;

  always_comb begin
    side_d.x_neg  = x_raw[COORD_W-1];
    side_d.y_neg  = y_raw[COORD_W-1];
    side_d.origin = (x_raw == '0) && (y_raw == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ax_q   <= ax_d;
      ay_q   <= ay_d;
      side_q <= side_d;
    end
  end

  // Magnitude and angle pipelines run side by side.
  c2p_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_vld_q),
    .ax_i    (ax_q),
    .ay_i    (ay_q),
    .valid_o (sq_vld),
    .mag_o   (sq_mag)
  );

  c2p_cordic u_cordic (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_vld_q),
    .ax_i     (ax_q),
    .ay_i     (ay_q),
    .side_i   (side_q),
    .valid_o  (cd_vld),
    .angle_o  (cd_angle),
    .origin_o (cd_origin)
  );

  // Delay the shorter path so both results leave together.
  if (MAG_PAD == 0) begin : g_mag_direct
    assign mag_vld_pad = sq_vld;
    assign mag_pad     = sq_mag;
  end else begin : g_mag_delay
    logic [MAG_PAD-1:0] vld_dly_q;
    logic [MAG_W-1:0]   mag_dly_q [MAG_PAD];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_dly_q <= '0;
      end else begin
        vld_dly_q <= MAG_PAD'({vld_dly_q, sq_vld});
      end
    end

    always_ff @(posedge clk_i) begin
      for (int i = MAG_PAD - 1; i > 0; i--) begin
        mag_dly_q[i] <= mag_dly_q[i-1];
      end
      mag_dly_q[0] <= sq_mag;
    end

    assign mag_vld_pad = vld_dly_q[MAG_PAD-1];
    assign mag_pad     = mag_dly_q[MAG_PAD-1];
  end

  if (ANG_PAD == 0) begin : g_ang_direct
    assign ang_vld_pad = cd_vld;
    assign ang_pad     = cd_angle;
    assign origin_pad  = cd_origin;
  end else begin : g_ang_delay
    logic [ANG_PAD-1:0] vld_dly_q;
    logic [ANG_PAD-1:0] org_dly_q;
    logic [ANGLE_W-1:0] ang_dly_q [ANG_PAD];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_dly_q <= '0;
      end else begin
        vld_dly_q <= ANG_PAD'({vld_dly_q, cd_vld});
      end
    end

    always_ff @(posedge clk_i) begin
      for (int i = ANG_PAD - 1; i > 0; i--) begin
        ang_dly_q[i] <= ang_dly_q[i-1];
      end
      ang_dly_q[0] <= cd_angle;
      org_dly_q    <= ANG_PAD'({org_dly_q, cd_origin});
    end

    assign ang_vld_pad = vld_dly_q[ANG_PAD-1];
    assign ang_pad     = ang_dly_q[ANG_PAD-1];
    assign origin_pad  = org_dly_q[ANG_PAD-1];
  end

  // Result ports.
  assign done_o      = ang_vld_pad;
  assign magnitude_o = mag_pad;
  assign angle_deg_o = ang_pad;
  assign at_origin_o = origin_pad;

  // Both pipelines must deliver each transaction in the same cycle.
  a_paths_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mag_vld_pad == ang_vld_pad)
    else $error("magnitude and angle pipelines out of step");

  // Every accepted transaction produces its result after the fixed latency.
  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(PIPE_LAT + 1) done_o)
    else $error("result missing after pipeline latency");

  // The origin reports zero magnitude and zero angle.
  a_origin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && at_origin_o |-> (magnitude_o == '0) && (angle_deg_o == '0))
    else $error("origin result not zero");

  // Any other point has a nonzero magnitude.
  a_nonzero_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !at_origin_o |-> magnitude_o != '0)
    else $error("zero magnitude for a point off the origin");

endmodule
